### design/rgr_pkg.sv
// ----------------------------------------------------------------------------
// rgr_pkg
// Shared widths, reset values and register map of the glyph run rasterizer.
// ----------------------------------------------------------------------------
package rgr_pkg;

    localparam int DIM_W    = 10;
    localparam int CUR_Y_W  = 11;
    localparam int DIV_W    = 11;
    localparam int SCALE_W  = 22;
    localparam int COLOR_W  = 24;
    localparam int ALPHA_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int COORD_W  = 16;
    localparam int MUL_A_W  = 11;
    localparam int PROD_W   = MUL_A_W + SCALE_W;

    localparam logic [DIM_W-1:0]   MAX_GLYPH_DIM = 10'd1023;
    localparam logic [DIM_W-1:0]   MIN_WIDTH     = 10'd5;
    localparam logic [15:0]        HALF_Q16      = 16'h8000;

    localparam logic [SCALE_W-1:0] SCALE_RST     = 22'd65536;
    localparam logic [COLOR_W-1:0] COLOR_RST     = 24'hFFFFFF;
    localparam logic [ALPHA_W-1:0] THRESH_RST    = 8'd30;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_COLOR  = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

endpackage

### design/rgr_div.sv
// ----------------------------------------------------------------------------
// rgr_div
// Restoring divider, one quotient bit per cycle, for cursor wrap on skip runs.
// ----------------------------------------------------------------------------
module rgr_div
    import rgr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [DIM_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DIV_W-1:0]   o_quo,
    output logic [DIM_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_dvd;
    logic [DIM_W-1:0]   r_rem;
    logic [DIM_W-1:0]   r_dsr;

    logic [DIM_W:0]     n_part;
    logic [DIM_W:0]     n_diff;
    logic               n_qbit;

    always_comb begin
        n_part = {r_rem, r_dvd[DIV_W-1]};
        n_diff = n_part - {1'b0, r_dsr};
        n_qbit = (n_part >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_qbit ? n_diff[DIM_W-1:0] : n_part[DIM_W-1:0];
                r_dvd <= {r_dvd[DIV_W-2:0], n_qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;
    assign o_rem  = r_rem;

endmodule

### design/rle_glyph_run_rasterizer_core.sv
// ----------------------------------------------------------------------------
// rle_glyph_run_rasterizer_core
// Decodes run-length coverage runs of a glyph into scaled screen rectangles.
// ----------------------------------------------------------------------------
// Input stream: one (alpha, length) run per transaction; tuser set latches
// glyph size and origin and clears the cursor before the run is applied.
// Output stream: one filled rectangle per transaction; tlast marks the last
// rectangle of a run. Configuration goes through the APB port; the user is to
// write it only while idle, which the block does not enforce. An accepted run
// is latched and checked; an ignored run ends there, a skip run then goes
// through the 11-step restoring divider, and a drawn run takes per rectangle
// four products through the one shared 11x22 multiplier and one emit state; a
// run yields up to 52 rectangles. Input ready is high only while idle.
// The output register holds one rectangle; when the receiver stalls the emit
// cycle waits, and the next run is accepted while the last rectangle waits.
// Reset loads the register defaults (scale 1.0, white, threshold 30), a
// glyph width of 5 with zero height, so runs are ignored until a new glyph.
// ----------------------------------------------------------------------------
module rle_glyph_run_rasterizer_core
    import rgr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input run stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // char_w[9:0] char_h[19:10] org_x[35:20] org_y[51:36]
    // run_alpha[59:52] run_length[67:60], zero fill above
    input  logic [71:0]        i_s_axis_tdata,
    // new_glyph[0]
    input  logic               i_s_axis_tuser,
    // output rectangle stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // rect_x[15:0] rect_y[31:16] rect_w[47:32] rect_h[63:48] rect_argb[95:64]
    output logic [95:0]        o_m_axis_tdata,
    output logic               o_m_axis_tlast,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MX0,
        S_MX1,
        S_MY0,
        S_MY1,
        S_EMIT
    } t_state;

    t_state               r_state;

    logic [SCALE_W-1:0]   r_scale;
    logic [COLOR_W-1:0]   r_color;
    logic [ALPHA_W-1:0]   r_thresh;

    logic [DIM_W-1:0]     r_width;
    logic [DIM_W-1:0]     r_height;
    logic [COORD_W-1:0]   r_ox;
    logic [COORD_W-1:0]   r_oy;
    logic [DIM_W-1:0]     r_cx;
    logic [CUR_Y_W-1:0]   r_cy;

    logic [ALPHA_W-1:0]   r_alpha;
    logic [COUNT_W-1:0]   r_count;
    logic [DIM_W-1:0]     r_xend;
    logic                 r_last;
    logic [PROD_W-1:0]    r_prod;
    logic [16:0]          r_sx;
    logic [16:0]          r_sy;
    logic [15:0]          r_w;

    logic                 r_ovalid;
    logic [95:0]          r_odata;
    logic                 r_olast;

    logic                 s_accept;
    logic                 cfg_wr;
    logic                 out_free;
    logic                 n_ignore;
    logic                 n_skip;
    logic [DIV_W-1:0]     n_total;
    logic [MUL_A_W-1:0]   mul_a;
    logic [PROD_W-1:0]    n_prod;
    logic [17:0]          n_round;
    logic [DIM_W-1:0]     n_take;
    logic [DIM_W-1:0]     n_gw;
    logic [DIM_W-1:0]     n_gh;

    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [DIM_W-1:0]     div_rem;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        begin
            clamp_dim = (v > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : v;
        end
    endfunction

    function automatic logic [15:0] span(input logic [17:0] e, input logic [16:0] s);
        logic [17:0] d;
        begin
            d = e - {1'b0, s};
            if (e > {1'b0, s}) begin
                span = (d > 18'h0FFFF) ? 16'hFFFF : d[15:0];
            end else begin
                span = 16'd1;
            end
        end
    endfunction

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_gw = i_s_axis_tdata[9:0];
        if (n_gw != '0 && n_gw < MIN_WIDTH) begin
            n_gw = MIN_WIDTH;
        end
        n_gw = clamp_dim(n_gw);
        n_gh = clamp_dim(i_s_axis_tdata[19:10]);
    end

    always_comb begin
        n_ignore = (r_count == '0) || (r_width == '0) ||
                   (r_cy >= {{(CUR_Y_W-DIM_W){1'b0}}, r_height});
        n_skip   = (r_alpha < r_thresh);
        n_total  = {1'b0, r_cx} + {{(DIV_W-COUNT_W){1'b0}}, r_count};
        n_take   = r_xend - r_cx;
    end

    always_comb begin
        unique case (r_state)
            S_MX0:   mul_a = {1'b0, r_cx};
            S_MX1:   mul_a = {1'b0, r_xend};
            S_MY0:   mul_a = r_cy;
            S_MY1:   mul_a = r_cy + 1'b1;
            default: mul_a = '0;
        endcase
        n_prod  = PROD_W'(mul_a) * PROD_W'(r_scale);
        n_round = 18'(({1'b0, r_prod} + (PROD_W+1)'(HALF_Q16)) >> 16);
    end

    rgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_CHECK && !n_ignore && n_skip),
        .i_dividend (n_total),
        .i_divisor  (r_width),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_scale  <= SCALE_RST;
            r_color  <= COLOR_RST;
            r_thresh <= THRESH_RST;
            r_width  <= MIN_WIDTH;
            r_height <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_SCALE:  r_scale  <= pwdata[SCALE_W-1:0];
                    REG_COLOR:  r_color  <= pwdata[COLOR_W-1:0];
                    REG_THRESH: r_thresh <= pwdata[ALPHA_W-1:0];
                    default:    ;
                endcase
            end

            if (r_ovalid && i_m_axis_tready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end

            if (r_state == S_MX0 || r_state == S_MX1 ||
                r_state == S_MY0 || r_state == S_MY1) begin
                r_prod <= n_prod;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_alpha <= i_s_axis_tdata[59:52];
                        r_count <= i_s_axis_tdata[67:60];
                        if (i_s_axis_tuser) begin
                            r_width  <= n_gw;
                            r_height <= n_gh;
                            r_ox     <= i_s_axis_tdata[35:20];
                            r_oy     <= i_s_axis_tdata[51:36];
                            r_cx     <= '0;
                            r_cy     <= '0;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (n_ignore) begin
                        r_state <= S_IDLE;
                    end else if (n_skip) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_MX0;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cx    <= div_rem;
                        r_cy    <= r_cy + div_quo;
                        r_state <= S_IDLE;
                    end
                end
                S_MX0: begin
                    if (n_total >= {1'b0, r_width}) begin
                        r_xend <= r_width;
                        r_last <= (n_total == {1'b0, r_width});
                    end else begin
                        r_xend <= n_total[DIM_W-1:0];
                        r_last <= 1'b1;
                    end
                    r_state <= S_MX1;
                end
                S_MX1: begin
                    r_sx    <= r_prod[PROD_W-1:16];
                    r_state <= S_MY0;
                end
                S_MY0: begin
                    r_w     <= span(n_round, r_sx);
                    r_state <= S_MY1;
                end
                S_MY1: begin
                    r_sy    <= r_prod[PROD_W-1:16];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= r_last;
                        r_odata  <= {r_alpha, r_color,
                                     span(n_round, r_sy),
                                     r_w,
                                     r_oy + r_sy[15:0],
                                     r_ox + r_sx[15:0]};
                        r_count  <= r_count - n_take[COUNT_W-1:0];
                        if (r_xend == r_width) begin
                            r_cx <= '0;
                            r_cy <= r_cy + 1'b1;
                        end else begin
                            r_cx <= r_xend;
                        end
                        r_state <= r_last ? S_IDLE : S_MX0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCALE:  prdata = {{(32-SCALE_W){1'b0}}, r_scale};
            REG_COLOR:  prdata = {{(32-COLOR_W){1'b0}}, r_color};
            REG_THRESH: prdata = {{(32-ALPHA_W){1'b0}}, r_thresh};
            default:    prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    a_cursor_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_width != '0) |-> (r_cx < r_width))
        else $error("cursor_x outside glyph row");

    a_take_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_xend > r_cx))
        else $error("rectangle piece with empty span");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_EMIT))
        else $error("output valid raised outside emit");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide wait");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rle_glyph_run_rasterizer_core. Coverage runs are
// streamed in with random gaps while the rectangle stream is stalled at
// random. A scoreboard class tracks the glyph cursor and the register
// settings, predicts every rectangle of each accepted run and compares the
// rectangles as they leave the block. Directed runs hit the corner cases,
// then random glyph sequences run under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import rgr_pkg::*;

    typedef struct packed {
        logic        new_glyph;
        logic [9:0]  char_w;
        logic [9:0]  char_h;
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [7:0]  run_alpha;
        logic [7:0]  run_length;
    } run_t;

    typedef struct packed {
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic [31:0] rect_argb;
        logic        run_done;
    } rect_t;

    class rect_scoreboard;
        int unsigned scale;
        int unsigned color;
        int unsigned thresh;
        int unsigned gw, gh, ox, oy, cx, cy;
        rect_t       rects_due[$];
        int          errors;
        int          n_runs, n_drawn, n_skipped, n_ignored, n_rects, n_writes;

        function new();
            scale  = 32'(SCALE_RST);
            color  = 32'(COLOR_RST);
            thresh = 32'(THRESH_RST);
            gw     = 32'(MIN_WIDTH);
            gh     = 0;
            ox     = 0;
            oy     = 0;
            cx     = 0;
            cy     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            n_writes++;
            case (idx)
                REG_SCALE:  scale  = value & 32'h003F_FFFF;
                REG_COLOR:  color  = value & 32'h00FF_FFFF;
                REG_THRESH: thresh = value & 32'h0000_00FF;
                default: ;
            endcase
        endfunction

        function logic [15:0] span_of(logic [63:0] hi, logic [63:0] lo);
            if (hi > lo)
                return (hi - lo > 64'hFFFF) ? 16'hFFFF : 16'(hi - lo);
            return 16'd1;
        endfunction

        // Returns 1 if the run is drawn or moves the cursor.
        function bit note_run(run_t r);
            int unsigned cnt, avail, take, total;
            logic [63:0] sx, sy, ex, ey;
            rect_t       e;
            n_runs++;
            if (r.new_glyph) begin
                gw = 32'(r.char_w);
                if (gw != 0 && gw < 32'(MIN_WIDTH)) gw = 32'(MIN_WIDTH);
                if (gw > 32'(MAX_GLYPH_DIM)) gw = 32'(MAX_GLYPH_DIM);
                gh = 32'(r.char_h);
                if (gh > 32'(MAX_GLYPH_DIM)) gh = 32'(MAX_GLYPH_DIM);
                ox = 32'(r.org_x);
                oy = 32'(r.org_y);
                cx = 0;
                cy = 0;
            end
            cnt = 32'(r.run_length);
            if (cnt == 0 || gw == 0 || cy >= gh) begin
                n_ignored++;
                return 1'b0;
            end
            if (32'(r.run_alpha) < thresh) begin
                total = cx + cnt;
                cx = total % gw;
                cy = cy + total / gw;
                n_skipped++;
                return 1'b1;
            end
            n_drawn++;
            e.rect_argb = {r.run_alpha, color[23:0]};
            while (cnt > 0) begin
                avail = gw - cx;
                take  = (cnt < avail) ? cnt : avail;
                sx = (64'(cx) * 64'(scale)) >> 16;
                sy = (64'(cy) * 64'(scale)) >> 16;
                ex = (64'(cx + take) * 64'(scale) + 64'(HALF_Q16)) >> 16;
                ey = (64'(cy + 1) * 64'(scale) + 64'(HALF_Q16)) >> 16;
                e.rect_x = 16'(64'(ox) + sx);
                e.rect_y = 16'(64'(oy) + sy);
                e.rect_w = span_of(ex, sx);
                e.rect_h = span_of(ey, sy);
                cx  = cx + take;
                cnt = cnt - take;
                if (cx >= gw) begin
                    cx = 0;
                    cy++;
                end
                e.run_done = (cnt == 0);
                rects_due.push_back(e);
            end
            return 1'b1;
        endfunction

        function void check_rect(logic [95:0] data, logic last);
            rect_t e;
            n_rects++;
            if (rects_due.size() == 0) begin
                $error("unexpected rectangle transaction: %h last %b", data, last);
                errors++;
                return;
            end
            e = rects_due.pop_front();
            if (data[15:0] !== e.rect_x) begin
                $error("rect_x mismatch: expected %0d, got %0d", e.rect_x, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.rect_y) begin
                $error("rect_y mismatch: expected %0d, got %0d", e.rect_y, data[31:16]);
                errors++;
            end
            if (data[47:32] !== e.rect_w) begin
                $error("rect_w mismatch: expected %0d, got %0d", e.rect_w, data[47:32]);
                errors++;
            end
            if (data[63:48] !== e.rect_h) begin
                $error("rect_h mismatch: expected %0d, got %0d", e.rect_h, data[63:48]);
                errors++;
            end
            if (data[95:64] !== e.rect_argb) begin
                $error("rect_argb mismatch: expected %h, got %h", e.rect_argb, data[95:64]);
                errors++;
            end
            if (last !== e.run_done) begin
                $error("run_done mismatch: expected %b, got %b", e.run_done, last);
                errors++;
            end
        endfunction

        function int pending();
            return rects_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        run_valid = 1'b0;
    logic [71:0] run_data = '0;
    logic        run_glyph = 1'b0;
    logic        rect_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [95:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [31:0] prdata;
    logic        pready;

    rect_scoreboard sb = new();
    bit rect_fire = 1'b0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_hold = 0;
    int runs_left = 0;

    rle_glyph_run_rasterizer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (run_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (run_data),
        .i_s_axis_tuser  (run_glyph),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rect_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rect_fire = i_rst_n && o_m_axis_tvalid && rect_ready;
        if (rect_fire) sb.check_rect(o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(negedge i_clk) begin
        if (rect_fire) begin
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            rx_hold = rx_calm ? 0 : $urandom_range(0, 17);
        end
        if (rx_hold > 0) begin
            rect_ready <= 1'b0;
            rx_hold--;
        end else begin
            rect_ready <= 1'b1;
        end
    end

    task automatic push_run(input run_t r, output bit active);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            run_valid <= 1'b0;
        end
        @(negedge i_clk);
        run_valid <= 1'b1;
        run_glyph <= r.new_glyph;
        run_data  <= {4'b0, r.run_length, r.run_alpha, r.org_y, r.org_x,
                      r.char_h, r.char_w};
        do @(posedge i_clk); while (!o_s_axis_tready);
        active = sb.note_run(r);
    endtask

    task automatic put_run(input logic ng, input int w, input int h, input int x,
                           input int y, input int a, input int n);
        bit act;
        push_run({ng, 10'(w), 10'(h), 16'(x), 16'(y), 8'(a), 8'(n)}, act);
    endtask

    // Hold the input until every rectangle has arrived, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        run_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input int scale, input int color, input int thresh);
        apb_write(REG_SCALE, 32'(scale));
        apb_write(REG_COLOR, 32'(color));
        apb_write(REG_THRESH, 32'(thresh));
    endtask

    function automatic run_t make_run();
        run_t r;
        int   pick;
        r = 69'({$urandom, $urandom, $urandom});
        if (runs_left == 0 || $urandom_range(0, 19) == 0) begin
            r.new_glyph = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick == 0)      r.char_w = 10'($urandom_range(0, 4));
            else if (pick < 3)  r.char_w = 10'($urandom_range(5, 1023));
            else                r.char_w = 10'($urandom_range(5, 24));
            pick = $urandom_range(0, 9);
            if (pick == 0)      r.char_h = '0;
            else if (pick == 1) r.char_h = 10'($urandom_range(1, 1023));
            else                r.char_h = 10'($urandom_range(1, 16));
            runs_left = $urandom_range(3, 12);
        end else begin
            r.new_glyph = 1'b0;
            runs_left--;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)      r.run_length = '0;
        else if (pick < 3)  r.run_length = 8'd255 - 8'($urandom_range(0, 1));
        else if (pick < 5)  r.run_length = 8'($urandom_range(1, 254));
        else                r.run_length = 8'($urandom_range(1, 40));
        return r;
    endfunction

    task automatic random_phase(input int items, input bit pause_midway);
        run_t r;
        bit   act;
        int   active;
        active = 0;
        runs_left = 0;
        while (active < items) begin
            r = make_run();
            push_run(r, act);
            active++;
            if (pause_midway && active == items / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        put_run(1'b0, 0, 0, 0, 0, 255, 10);
        put_run(1'b1, 8, 4, 100, 200, 255, 3);
        put_run(1'b0, 0, 0, 0, 0, 29, 10);
        put_run(1'b0, 0, 0, 0, 0, 30, 20);
        put_run(1'b0, 0, 0, 0, 0, 255, 0);
        put_run(1'b1, 0, 5, 7, 7, 200, 10);
        put_run(1'b1, 1, 1023, 65535, 65535, 255, 255);
        put_run(1'b0, 0, 0, 0, 0, 255, 3);
        put_run(1'b0, 0, 0, 0, 0, 255, 255);
        put_run(1'b1, 1023, 1023, 0, 0, 0, 255);
        put_run(1'b0, 0, 0, 0, 0, 128, 255);
        put_run(1'b1, 3, 1, 300, 40, 255, 12);
        put_run(1'b0, 0, 0, 0, 0, 255, 1);
        put_run(1'b1, 4, 2, 9, 9, 10, 255);
        put_run(1'b0, 0, 0, 0, 0, 255, 5);
        put_run(1'b1, 10, 0, 1, 1, 255, 5);
        put_run(1'b1, 1023, 1, 12345, 54321, 255, 255);
        put_run(1'b0, 1023, 1023, 65535, 65535, 254, 254);
        drain();

        set_regs(4194303, 0, 0);
        put_run(1'b1, 1023, 1023, 1, 2, 0, 255);
        put_run(1'b0, 0, 0, 0, 0, 1, 255);
        drain();

        set_regs(0, 24'hA5A5A5, 255);
        put_run(1'b1, 6, 3, 500, 600, 254, 7);
        put_run(1'b0, 0, 0, 0, 0, 255, 12);
        drain();

        set_regs(65536, 24'h3C5AF0, 30);
        random_phase(20, 1'b0);
        set_regs(4194303, 0, 0);
        random_phase(20, 1'b1);
        set_regs(0, 24'hFFFFFF, 255);
        random_phase(20, 1'b0);
        set_regs($urandom_range(0, 4194303), $urandom & 24'hFFFFFF, $urandom_range(0, 255));
        random_phase(20, 1'b0);
        set_regs(98304, $urandom & 24'hFFFFFF, 128);
        random_phase(20, 1'b0);

        $display("Covered %0d runs: %0d drawn, %0d skipped, %0d ignored.",
                 sb.n_runs, sb.n_drawn, sb.n_skipped, sb.n_ignored);
        $display("Checked %0d rectangles across %0d register writes.",
                 sb.n_rects, sb.n_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
